>>> hw/rtl/lpp_pkg.sv
// Shared types and constants for the lidar packet parser.
// No dependencies; every other file imports this package.
package lpp_pkg;

    localparam int unsigned ByteW     = 8;
    localparam int unsigned AngleW    = 9;
    localparam int unsigned DistW     = 14;
    localparam int unsigned QualW     = 16;
    localparam int unsigned SpeedW    = 16;
    localparam int unsigned IndexW    = 7;
    localparam int unsigned DistHighW = DistW - ByteW;

    localparam logic [ByteW-1:0] StartByte = 8'd250;
    localparam logic [ByteW-1:0] IndexLow  = 8'd160;
    localparam logic [ByteW-1:0] IndexHigh = 8'd249;

    // Byte position inside one four-byte reading.
    localparam logic [1:0] PosDistLo = 2'd0;
    localparam logic [1:0] PosDistHi = 2'd1;
    localparam logic [1:0] PosQualLo = 2'd2;
    localparam logic [1:0] PosQualHi = 2'd3;

    // Reading byte counter: two bits of slot, two bits of position.
    localparam logic [3:0] LastReadByte = 4'd15;
    localparam logic [1:0] LastSlot     = 2'd3;

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_INDEX,
        ST_SPEED_LO,
        ST_SPEED_HI,
        ST_READING
    } t_state;

    typedef struct packed {
        logic [AngleW-1:0] angle;
        logic [DistW-1:0]  distance;
        logic [QualW-1:0]  quality;
        logic [SpeedW-1:0] speed_raw;
        logic              last_of_packet;
    } t_result;

endpackage

>>> hw/rtl/lpp_byte_if.sv
// Byte stream channel: valid/ready handshake carrying one received byte.
// Depends on lpp_pkg.
interface lpp_byte_if
    import lpp_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [ByteW-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> hw/rtl/lpp_result_if.sv
// Result channel: valid/ready handshake carrying one decoded reading.
// Depends on lpp_pkg.
interface lpp_result_if
    import lpp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [AngleW-1:0] angle;
    logic [DistW-1:0]  distance;
    logic [QualW-1:0]  quality;
    logic [SpeedW-1:0] speed_raw;
    logic              last_of_packet;

    modport source (output valid, output angle, output distance, output quality,
                    output speed_raw, output last_of_packet, input ready);
    modport sink   (input valid, input angle, input distance, input quality,
                    input speed_raw, input last_of_packet, output ready);
endinterface

>>> hw/rtl/lidar_packet_parser.sv
// Top level of the lidar packet parser: input register, framing core, result register.
// Depends on lpp_pkg, lpp_byte_if, lpp_result_if and lpp_parse_core.
// o_res.valid rises when a reading's last byte steps from input to result register.
// Throughput: one byte per cycle, sustained, while o_res keeps up; the phase
//   update and field capture of each byte fit between the input and result registers.
// Reset (synchronous, active low): both stages empty, parser hunting for a start byte.
module lidar_packet_parser
    import lpp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    lpp_byte_if.sink         i_rx,
    lpp_result_if.source     o_res
);

    // Input stage: hold one accepted beat until the core steps on it.
    logic             r_in_valid;
    logic [ByteW-1:0] r_in_byte;

    // Result stage: hold one reading until the sink takes it.
    logic             r_out_valid;
    t_result          r_out;

    logic             out_free;
    logic             step;
    logic             core_valid;
    t_result          core_res;

    // The result register can load when empty or when its beat leaves this cycle.
    assign out_free  = !r_out_valid || o_res.ready;
    // Advance the core whenever a byte waits and any result it makes has room.
    assign step      = r_in_valid && out_free;
    assign i_rx.ready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    lpp_parse_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (r_in_byte),
        .o_res_valid (core_valid),
        .o_res       (core_res)
    );

    // Load a new reading or drop the delivered one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step && core_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && core_valid) begin
            r_out <= core_res;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.angle          = r_out.angle;
    assign o_res.distance       = r_out.distance;
    assign o_res.quality        = r_out.quality;
    assign o_res.speed_raw      = r_out.speed_raw;
    assign o_res.last_of_packet = r_out.last_of_packet;

endmodule

>>> hw/rtl/lpp_parse_core.sv
// Packet framing state machine and field capture for the lidar parser.
// Depends on lpp_pkg.
module lpp_parse_core
    import lpp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [ByteW-1:0] i_byte,
    output logic             o_res_valid,
    output t_result          o_res
);

    t_state                r_state, n_state;
    logic [3:0]            r_cnt, n_cnt;
    logic [IndexW-1:0]     r_index;
    logic [SpeedW-1:0]     r_speed;
    logic [ByteW-1:0]      r_dist_lo;
    logic [DistHighW-1:0]  r_dist_hi;
    logic [ByteW-1:0]      r_qual_lo;
    logic                  index_ok;
    logic [IndexW-1:0]     index_off;
    logic [1:0]            pos;
    logic [1:0]            slot;

    assign index_ok  = (i_byte >= IndexLow) && (i_byte <= IndexHigh);
    assign index_off = IndexW'(i_byte - IndexLow);
    assign pos       = r_cnt[1:0];
    assign slot      = r_cnt[3:2];

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        o_res_valid = 1'b0;
        unique case (r_state)
            ST_HUNT: begin
                if (i_byte == StartByte) n_state = ST_INDEX;
            end
            ST_INDEX: begin
                if (index_ok) begin
                    n_state = ST_SPEED_LO;
                end else if (i_byte != StartByte) begin
                    n_state = ST_HUNT;
                end
            end
            ST_SPEED_LO: n_state = ST_SPEED_HI;
            ST_SPEED_HI: begin
                n_state = ST_READING;
                n_cnt   = '0;
            end
            ST_READING: begin
                n_cnt       = r_cnt + 4'd1;
                o_res_valid = (pos == PosQualHi);
                if (r_cnt == LastReadByte) n_state = ST_HUNT;
            end
            default: n_state = ST_HUNT;
        endcase
    end

    always_comb begin
        o_res.angle          = {r_index, 2'b00} + {{(AngleW-2){1'b0}}, slot};
        o_res.distance       = {r_dist_hi, r_dist_lo};
        o_res.quality        = {i_byte, r_qual_lo};
        o_res.speed_raw      = r_speed;
        o_res.last_of_packet = (slot == LastSlot);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HUNT;
            r_cnt   <= '0;
        end else if (i_step) begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Field capture; every field is written before a reading uses it.
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            case (r_state)
                ST_INDEX: begin
                    if (index_ok) r_index <= index_off;
                end
                ST_SPEED_LO: r_speed[ByteW-1:0]      <= i_byte;
                ST_SPEED_HI: r_speed[SpeedW-1:ByteW] <= i_byte;
                ST_READING: begin
                    case (pos)
                        PosDistLo: r_dist_lo <= i_byte;
                        PosDistHi: r_dist_hi <= i_byte[DistHighW-1:0];
                        PosQualLo: r_qual_lo <= i_byte;
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

endmodule

>>> sim/lpp_reading_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the lidar packet parser: decodes accepted byte beats into expected
// readings and compares them with result beats. Depends on lpp_pkg and both channel interfaces.
module lpp_reading_checker
    import lpp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    lpp_byte_if         i_rx,
    lpp_result_if       i_res,
    output int unsigned o_fail_count,
    output int unsigned o_pending
);

    t_state               frame_state;
    logic [3:0]           read_cnt;
    logic [IndexW-1:0]    pkt_index;
    logic [SpeedW-1:0]    speed_word;
    logic [ByteW-1:0]     dist_lo;
    logic [DistHighW-1:0] dist_hi;
    logic [ByteW-1:0]     qual_lo;
    t_result              expected_readings[$];
    int unsigned          fail_count = 0;

    // Advance the framing state by one byte; queue a reading on its last byte.
    task automatic decode_byte(input logic [ByteW-1:0] b);
        t_result r;
        case (frame_state)
            ST_INDEX: begin
                if (b >= IndexLow && b <= IndexHigh) begin
                    pkt_index   = IndexW'(b - IndexLow);
                    frame_state = ST_SPEED_LO;
                end else if (b != StartByte) begin
                    frame_state = ST_HUNT;
                end
            end
            ST_SPEED_LO: begin
                speed_word[7:0] = b;
                frame_state     = ST_SPEED_HI;
            end
            ST_SPEED_HI: begin
                speed_word[15:8] = b;
                read_cnt         = '0;
                frame_state      = ST_READING;
            end
            ST_READING: begin
                case (read_cnt[1:0])
                    PosDistLo: dist_lo = b;
                    PosDistHi: dist_hi = b[DistHighW-1:0];
                    PosQualLo: qual_lo = b;
                    PosQualHi: begin
                        r.angle          = AngleW'(4 * pkt_index + read_cnt[3:2]);
                        r.distance       = {dist_hi, dist_lo};
                        r.quality        = {b, qual_lo};
                        r.speed_raw      = speed_word;
                        r.last_of_packet = (read_cnt[3:2] == LastSlot);
                        expected_readings.push_back(r);
                    end
                endcase
                if (read_cnt == LastReadByte) begin
                    frame_state = ST_HUNT;
                end else begin
                    read_cnt = read_cnt + 4'd1;
                end
            end
            default: frame_state = (b == StartByte) ? ST_INDEX : ST_HUNT;
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_reading();
        t_result want;
        if (expected_readings.size() == 0) begin
            $error("result beat with no reading pending: angle %0d", i_res.angle);
            fail_count++;
        end else begin
            want = expected_readings.pop_front();
            check_field("angle", 32'(want.angle), 32'(i_res.angle));
            check_field("distance", 32'(want.distance), 32'(i_res.distance));
            check_field("quality", 32'(want.quality), 32'(i_res.quality));
            check_field("speed_raw", 32'(want.speed_raw), 32'(i_res.speed_raw));
            check_field("last_of_packet", 32'(want.last_of_packet),
                        32'(i_res.last_of_packet));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_state = ST_HUNT;
            read_cnt    = '0;
            pkt_index   = '0;
            speed_word  = '0;
            dist_lo     = '0;
            dist_hi     = '0;
            qual_lo     = '0;
            expected_readings.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                check_reading();
            end
            if (i_rx.valid && i_rx.ready) begin
                decode_byte(i_rx.rx_byte);
            end
        end
        o_pending    <= expected_readings.size();
        o_fail_count <= fail_count;
    end

endmodule

>>> sim/tb_lidar_packet_parser.sv
`timescale 1ns / 1ps
// Testbench top for the lidar packet parser: clock, reset, byte stimulus and result backpressure.
// Depends on lpp_pkg, both channel interfaces, lidar_packet_parser and lpp_reading_checker.
module tb_lidar_packet_parser
    import lpp_pkg::*;
();

    logic i_clk = 1'b0;
    logic i_rst_n;

    // Idle rates in percent per cycle, changed between phases of the run.
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    // Set by the stimulus to ask the receiver for one long hold-off.
    bit          hold_req = 1'b0;
    int unsigned beats_sent = 0;
    int unsigned fail_count;
    int unsigned pending;

    lpp_byte_if   rx_if ();
    lpp_result_if res_if ();

    lidar_packet_parser uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if)
    );

    lpp_reading_checker reading_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx         (rx_if),
        .i_res        (res_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    // Offer one byte beat, after a random number of idle cycles, and hold it
    // until the parser takes it. Return on the edge of acceptance.
    task automatic send_byte(input logic [ByteW-1:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            rx_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_if.ready) @(posedge i_clk);
        beats_sent++;
    endtask

    // Bias payload bytes toward all-zeros and all-ones so that the masked
    // distance high byte and the field extremes show up often.
    function automatic logic [ByteW-1:0] pick_byte();
        logic [ByteW-1:0] b;
        case ($urandom_range(7))
            0:       b = 8'h00;
            1:       b = 8'hFF;
            default: b = 8'($urandom);
        endcase
        return b;
    endfunction

    // Send one well-formed packet with random content, checksum bytes included.
    task automatic send_packet();
        int unsigned sel;
        logic [ByteW-1:0] idx;
        sel = $urandom_range(9);
        if (sel == 0) begin
            idx = IndexLow;
        end else if (sel == 1) begin
            idx = IndexHigh;
        end else begin
            idx = 8'($urandom_range(IndexLow, IndexHigh));
        end
        send_byte(StartByte);
        // Repeat the start byte now and then; the parser must keep waiting for the index.
        if ($urandom_range(7) == 0) begin
            send_byte(StartByte);
        end
        send_byte(idx);
        // Two speed bytes, then sixteen reading bytes.
        repeat (18) send_byte(pick_byte());
        // Checksum bytes: the parser treats them as hunt bytes.
        repeat (2) send_byte(8'($urandom));
    endtask

    // Mostly whole packets; the rest is noise and broken starts.
    task automatic run_random(input int unsigned n_beats);
        int unsigned stop_at;
        int unsigned n_noise;
        stop_at = beats_sent + n_beats;
        while (beats_sent < stop_at) begin
            if ($urandom_range(9) < 8) begin
                send_packet();
            end else begin
                n_noise = $urandom_range(1, 4);
                repeat (n_noise) send_byte(($urandom_range(3) == 0) ? StartByte : 8'($urandom));
            end
        end
    endtask

    task automatic send_directed();
        // Ignore a non-start byte while hunting.
        send_byte(8'h00);
        // Keep waiting for the index across a repeated start byte, then drop
        // back to hunting on an index just below the range.
        send_byte(StartByte);
        send_byte(StartByte);
        send_byte(8'd159);
        // Drop back to hunting on an index just above the start byte.
        send_byte(StartByte);
        send_byte(8'd251);
        // Full packet at the highest index, speed 0xFF00.
        send_byte(StartByte);
        send_byte(IndexHigh);
        send_byte(8'h00);
        send_byte(8'hFF);
        // All-ones reading: distance high byte masked to six bits.
        repeat (4) send_byte(8'hFF);
        // All-zeros reading.
        repeat (4) send_byte(8'h00);
        // Upper two bits of the distance high byte only: they must vanish.
        send_byte(8'h5A);
        send_byte(8'hC0);
        send_byte(8'h01);
        send_byte(8'h80);
        // Last reading of the packet.
        send_byte(8'h34);
        send_byte(8'h12);
        send_byte(8'hA5);
        send_byte(8'h5A);
    endtask

    // Receiver: random backpressure, plus one long hold-off on request so
    // that the parser fills up and stalls its byte input.
    initial begin : receiver
        int unsigned hold_left;
        bit          hold_used;
        hold_left = 0;
        hold_used = 1'b0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_used) begin
                hold_left = 300;
                hold_used = 1'b1;
            end
            if (hold_left != 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin : stimulus
        i_rst_n       <= 1'b0;
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_directed();

        // Sender nearly always offers, receiver mostly stalls.
        tx_idle_pct = 6;
        rx_idle_pct = 81;
        run_random(400);

        // Sender mostly idle, receiver nearly always ready.
        tx_idle_pct = 81;
        rx_idle_pct = 6;
        run_random(400);

        // No idling at all, except one long receiver hold-off at the start.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req    = 1'b1;
        run_random(350);

        rx_if.valid <= 1'b0;
        // Let the last accepted beat reach the checker before draining.
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("tb_lidar_packet_parser passed");
        end else begin
            $display("tb_lidar_packet_parser failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin : watchdog
        #2000000;
        $display("tb_lidar_packet_parser failed");
        $finish;
    end

endmodule
